@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

  // Threshold register width
  localparam int REG_W = 16;

  // Press state codes
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DEBOUNCE = 2'd1;
  localparam logic [1:0] ST_PRESSED  = 2'd2;
  localparam logic [1:0] ST_LONG     = 2'd3;

  // Event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_SHORT    = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;

  // Register reset values
  localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd2;
  localparam logic [REG_W-1:0] SHORT_RST    = 16'd5;
  localparam logic [REG_W-1:0] LONG_RST     = 16'd50;

  // Thresholds handed to the classifier
  typedef struct packed {
    logic [REG_W-1:0] debounce_ticks;
    logic [REG_W-1:0] short_ticks;
    logic [REG_W-1:0] long_ticks;
  } thresh_t;

  // Per-cycle item controls handed to the classifier
  typedef struct packed {
    logic tick_en;
    logic read_en;
    logic pressed;
  } item_ctl_t;

endpackage

@@ rtl/bpc_fsm.sv @@
module bpc_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bpc_pkg::thresh_t   thresh,
  input  bpc_pkg::item_ctl_t ctl,
  output logic [1:0]         pending_event
);

  localparam int CMP_W = (COUNT_WIDTH > bpc_pkg::REG_W) ? COUNT_WIDTH : bpc_pkg::REG_W;

  logic [1:0]             press_state;
  logic [1:0]             press_state_next;
  logic [COUNT_WIDTH-1:0] press_ticks;
  logic [COUNT_WIDTH-1:0] press_ticks_next;
  logic [1:0]             pending_event_next;
  logic [COUNT_WIDTH-1:0] ticks_inc;
  logic [CMP_W-1:0]       ticks_cmp;
  logic                   debounce_met;
  logic                   short_met;
  logic                   long_met;

  // Saturating increment and threshold compares
  assign ticks_inc    = (press_ticks == {COUNT_WIDTH{1'b1}}) ? press_ticks
                                                             : press_ticks + 1'b1;
  assign ticks_cmp    = CMP_W'(ticks_inc);
  assign debounce_met = ticks_cmp >= CMP_W'(thresh.debounce_ticks);
  assign short_met    = ticks_cmp >= CMP_W'(thresh.short_ticks);
  assign long_met     = ticks_cmp >= CMP_W'(thresh.long_ticks);

  // Next state for a tick or a read
  always_comb begin
    press_state_next   = press_state;
    press_ticks_next   = press_ticks;
    pending_event_next = pending_event;
    if (ctl.read_en) begin
      pending_event_next = bpc_pkg::EV_NONE;
    end else if (ctl.tick_en) begin
      case (press_state)
        bpc_pkg::ST_IDLE: begin
          if (ctl.pressed) begin
            press_state_next = bpc_pkg::ST_DEBOUNCE;
            press_ticks_next = '0;
          end
        end
        bpc_pkg::ST_DEBOUNCE: begin
          press_ticks_next = ticks_inc;
          if (debounce_met) begin
            if (ctl.pressed) begin
              press_state_next = bpc_pkg::ST_PRESSED;
              press_ticks_next = '0;
            end else begin
              press_state_next = bpc_pkg::ST_IDLE;
            end
          end
        end
        bpc_pkg::ST_PRESSED: begin
          press_ticks_next = ticks_inc;
          if (!ctl.pressed) begin
            if (short_met) pending_event_next = bpc_pkg::EV_SHORT;
            press_state_next = bpc_pkg::ST_IDLE;
          end else if (long_met) begin
            pending_event_next = bpc_pkg::EV_LONG;
            press_state_next   = bpc_pkg::ST_LONG;
          end
        end
        default: begin
          if (!ctl.pressed) press_state_next = bpc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_state   <= bpc_pkg::ST_IDLE;
      press_ticks   <= '0;
      pending_event <= bpc_pkg::EV_NONE;
    end else begin
      press_state   <= press_state_next;
      press_ticks   <= press_ticks_next;
      pending_event <= pending_event_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A read always leaves nothing pending
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.read_en |=> pending_event == bpc_pkg::EV_NONE)
    else $error("pending event not cleared by read");

  // Long-pressed is entered only from pressed, and then flags a long event
  a_long_entry: assert property (@(posedge clk) disable iff (rst)
    (press_state != bpc_pkg::ST_LONG) ##1 (press_state == bpc_pkg::ST_LONG) |->
      ($past(press_state) == bpc_pkg::ST_PRESSED && pending_event == bpc_pkg::EV_LONG))
    else $error("bad entry into long-pressed state");

  // Only a tick moves the state machine
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.tick_en |=> $stable(press_state) && $stable(press_ticks))
    else $error("state changed without a tick");

  // Pending event never holds the unused code
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    pending_event != 2'd3)
    else $error("unused event code pending");
`endif

endmodule

@@ rtl/button_press_classifier_core.sv @@
// A read item's result is registered into the output register, or into the skid stage if the output is stalled.
// Throughput: one item per cycle while the skid stage is empty; a tick or read is a single state update.
// Results wait in an output register plus a one-entry skid stage; input
// stalls while the skid stage holds a result.
// Reset (rst, synchronous, active high): idle state, no pending event,
// thresholds back to 2 / 5 / 50 ticks, output empty.
module button_press_classifier_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] button level (0 pressed), [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  // Result item stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] event_code, [7:2] zero
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bpc_pkg::thresh_t   thresh;
  bpc_pkg::item_ctl_t ctl;
  logic [1:0]         pending_event;
  logic               s_accept;
  logic               cfg_write;
  logic [1:0]         reg_idx;
  logic               out_valid;
  logic [1:0]         out_code;
  logic               skid_valid;
  logic [1:0]         skid_code;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.debounce_ticks <= bpc_pkg::DEBOUNCE_RST;
      thresh.short_ticks    <= bpc_pkg::SHORT_RST;
      thresh.long_ticks     <= bpc_pkg::LONG_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        bpc_pkg::REG_DEBOUNCE: thresh.debounce_ticks <= pwdata[bpc_pkg::REG_W-1:0];
        bpc_pkg::REG_SHORT:    thresh.short_ticks    <= pwdata[bpc_pkg::REG_W-1:0];
        bpc_pkg::REG_LONG:     thresh.long_ticks     <= pwdata[bpc_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_DEBOUNCE: prdata = 32'(thresh.debounce_ticks);
      bpc_pkg::REG_SHORT:    prdata = 32'(thresh.short_ticks);
      bpc_pkg::REG_LONG:     prdata = 32'(thresh.long_ticks);
      default:               prdata = '0;
    endcase
  end

  // Item decode
  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ctl.tick_en   = s_accept && (s_axis_tuser[0] == bpc_pkg::OP_TICK);
  assign ctl.read_en   = s_accept && (s_axis_tuser[0] == bpc_pkg::OP_READ);
  assign ctl.pressed   = !s_axis_tdata[0];

  bpc_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk           (clk),
    .rst           (rst),
    .thresh        (thresh),
    .ctl           (ctl),
    .pending_event (pending_event)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid  <= skid_valid || ctl.read_en;
      skid_valid <= 1'b0;
    end else if (ctl.read_en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_code <= skid_valid ? skid_code : pending_event;
    end else if (ctl.read_en) begin
      skid_code <= pending_event;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_code};

`ifndef NO_ASSERTIONS
  // Skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  // A stalled full output spills an accepted read into the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && ctl.read_en) |=> skid_valid)
    else $error("read result dropped on output stall");

  // A read into an empty output shows up on the next cycle
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && ctl.read_en) |=> m_axis_tvalid)
    else $error("read result missing");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 16;
  localparam int RANDOM_PER_PHASE = 140;

  typedef struct packed {
    logic op;
    logic pin;
  } btn_item_t;

  // DUT ports; inputs driven to known values from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] button level (0 pressed), [7:1] zero
  logic [0:0]  s_axis_tuser = '0;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [1:0] event_code, [7:2] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pending stimulus and expected event codes
  btn_item_t   press_item_q[$];
  logic [1:0]  event_due_q[$];

  // Press classifier prediction state
  logic [bpc_pkg::REG_W-1:0] thr_debounce = bpc_pkg::DEBOUNCE_RST;
  logic [bpc_pkg::REG_W-1:0] thr_short    = bpc_pkg::SHORT_RST;
  logic [bpc_pkg::REG_W-1:0] thr_long     = bpc_pkg::LONG_RST;
  logic [1:0]                pred_state   = bpc_pkg::ST_IDLE;
  logic [CNT_W-1:0]          pred_ticks   = '0;
  logic [1:0]                pred_event   = bpc_pkg::EV_NONE;

  // Bookkeeping
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned read_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned short_cnt = 0;
  int unsigned long_cnt = 0;
  int unsigned write_cnt = 0;
  int unsigned err_cnt = 0;

  // Sender burst state
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  btn_item_t   drv_item;

  // Receiver stall state
  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;

  button_press_classifier_core #(
    .COUNT_WIDTH(CNT_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the predicted state machine by one tick
  task automatic classify_tick(input logic pressed);
    case (pred_state)
      bpc_pkg::ST_IDLE: begin
        if (pressed) begin
          pred_state = bpc_pkg::ST_DEBOUNCE;
          pred_ticks = '0;
        end
      end
      bpc_pkg::ST_DEBOUNCE: begin
        if (pred_ticks != {CNT_W{1'b1}}) pred_ticks++;
        if (pred_ticks >= thr_debounce) begin
          if (pressed) begin
            pred_state = bpc_pkg::ST_PRESSED;
            pred_ticks = '0;
          end else begin
            pred_state = bpc_pkg::ST_IDLE;
          end
        end
      end
      bpc_pkg::ST_PRESSED: begin
        if (pred_ticks != {CNT_W{1'b1}}) pred_ticks++;
        if (!pressed) begin
          if (pred_ticks >= thr_short) pred_event = bpc_pkg::EV_SHORT;
          pred_state = bpc_pkg::ST_IDLE;
        end else if (pred_ticks >= thr_long) begin
          pred_event = bpc_pkg::EV_LONG;
          pred_state = bpc_pkg::ST_LONG;
        end
      end
      default: begin
        if (!pressed) pred_state = bpc_pkg::ST_IDLE;
      end
    endcase
  endtask

  // Accepted item: tick updates state, read yields the pending event
  task automatic classify_item(input logic op, input logic pin);
    if (op == bpc_pkg::OP_TICK) begin
      classify_tick(pin == 1'b0);
    end else begin
      event_due_q.push_back(pred_event);
      read_cnt++;
      if (pred_event == bpc_pkg::EV_SHORT) short_cnt++;
      if (pred_event == bpc_pkg::EV_LONG) long_cnt++;
      pred_event = bpc_pkg::EV_NONE;
    end
  endtask

  task automatic push_ticks(input logic pin, input int unsigned n);
    btn_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.op = bpc_pkg::OP_TICK;
      it.pin = pin;
      press_item_q.push_back(it);
      queued_cnt++;
    end
  endtask

  // Pin level of a read is ignored, so randomize it
  task automatic push_read();
    btn_item_t it;
    it.op = bpc_pkg::OP_READ;
    it.pin = 1'($urandom_range(0, 1));
    press_item_q.push_back(it);
    queued_cnt++;
  endtask

  // One press with random length around the thresholds, or a burst of noise
  task automatic queue_random_press();
    int unsigned base;
    int unsigned target;
    int unsigned n;
    btn_item_t it;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++) push_ticks(1'($urandom_range(0, 1)), 1);
      end
      base = 1 + ((thr_debounce == 0) ? 1 : thr_debounce);
      case ($urandom_range(0, 2))
        0:       target = thr_short;
        1:       target = thr_long;
        default: target = $urandom_range(0, thr_long + 4);
      endcase
      n = base + target + $urandom_range(0, 4);
      n = (n > 2) ? n - 2 : 1;
      for (int unsigned i = 0; i < n; i++) begin
        push_ticks(1'b0, 1);
        if ($urandom_range(0, 11) == 0) push_read();
      end
      push_ticks(1'b1, $urandom_range(1, 3));
      if ($urandom_range(0, 2) != 0) push_read();
    end else begin
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++) begin
        it.op = 1'($urandom_range(0, 1));
        it.pin = 1'($urandom_range(0, 1));
        press_item_q.push_back(it);
        queued_cnt++;
      end
    end
  endtask

  // Wait until every item is taken and every result is back
  task automatic wait_idle();
    while (!(press_item_q.size() == 0 && sent_cnt == taken_cnt && event_due_q.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write followed by a read-back
  task automatic write_reg(input logic [1:0] idx, input logic [bpc_pkg::REG_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'b0, val}) begin
      $error("prdata mismatch at reg %0d: expected %0d, actual %0d", idx, val, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bpc_pkg::REG_DEBOUNCE: thr_debounce = val;
      bpc_pkg::REG_SHORT:    thr_short = val;
      default:               thr_long = val;
    endcase
    write_cnt++;
  endtask

  task automatic set_thresholds(input logic [bpc_pkg::REG_W-1:0] deb,
                                input logic [bpc_pkg::REG_W-1:0] shrt,
                                input logic [bpc_pkg::REG_W-1:0] lng);
    wait_idle();
    write_reg(bpc_pkg::REG_DEBOUNCE, deb);
    write_reg(bpc_pkg::REG_SHORT, shrt);
    write_reg(bpc_pkg::REG_LONG, lng);
  endtask

  // Sender: bursts of random length, random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (sent_cnt != taken_cnt) begin
      // item still on the bus, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (press_item_q.size() > 0) begin
      drv_item = press_item_q.pop_front();
      s_axis_tdata <= {7'b0, drv_item.pin};
      s_axis_tuser <= drv_item.op;
      s_axis_tvalid <= 1'b1;
      sent_cnt++;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: rotating stall pattern plus one long hold-off
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_armed && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cyc / 150) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cyc % 5 != 0);
      endcase
    end
  end

  // Monitor: check results, then predict from accepted items
  always @(posedge clk) begin : monitor
    logic [1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (event_due_q.size() == 0) begin
          $error("unexpected result: event_code %0d", m_axis_tdata[1:0]);
          err_cnt++;
        end else begin
          want = event_due_q.pop_front();
          if (m_axis_tdata[1:0] !== want) begin
            $error("event_code mismatch: expected %0d, actual %0d", want, m_axis_tdata[1:0]);
            err_cnt++;
          end
          if (m_axis_tdata[7:2] !== 6'b0) begin
            $error("tdata pad mismatch: expected 0, actual %0d", m_axis_tdata[7:2]);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_cnt++;
        classify_item(s_axis_tuser[0], s_axis_tdata[0]);
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int unsigned start;
    logic [bpc_pkg::REG_W-1:0] cfg_tab[6][3];
    cfg_tab = '{'{16'd0, 16'd0, 16'd0}, '{16'd2, 16'd5, 16'd50},
                '{16'd3, 16'd4, 16'd12}, '{16'd1, 16'd8, 16'd4},
                '{16'd0, 16'd1, 16'd2}, '{16'd5, 16'd10, 16'd30}};
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed, reset thresholds: empty read, short press, too short, bounce
    push_read();
    push_ticks(1'b0, 9);
    push_ticks(1'b1, 1);
    push_read();
    push_read();
    push_ticks(1'b0, 4);
    push_ticks(1'b1, 1);
    push_read();
    push_ticks(1'b0, 1);
    push_ticks(1'b1, 2);
    push_read();

    // Directed, tight thresholds: long press with a read while held,
    // then a short press that overwrites the pending long event
    set_thresholds(16'd1, 16'd2, 16'd4);
    push_ticks(1'b0, 8);
    push_read();
    push_ticks(1'b0, 6);
    push_ticks(1'b1, 1);
    push_ticks(1'b0, 8);
    push_ticks(1'b1, 1);
    push_ticks(1'b0, 5);
    push_ticks(1'b1, 1);
    push_read();

    // Random presses over several threshold settings
    for (int p = 0; p < 6; p++) begin
      set_thresholds(cfg_tab[p][0], cfg_tab[p][1], cfg_tab[p][2]);
      if (p == 2) hold_armed = 1'b1;
      start = queued_cnt;
      while (queued_cnt - start < RANDOM_PER_PHASE) queue_random_press();
    end

    // Maximum short and long times: a held button fires neither event
    set_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
    push_ticks(1'b0, 24);
    push_read();
    push_ticks(1'b1, 2);
    push_read();

    // Zero short and long thresholds: long press on the first tick after debounce
    set_thresholds(16'd3, 16'd0, 16'd0);
    push_ticks(1'b0, 6);
    push_read();
    push_ticks(1'b1, 1);
    push_read();

    wait_idle();
    repeat (5) @(posedge clk);
    if (event_due_q.size() != 0) begin
      $error("%0d expected results never arrived", event_due_q.size());
      err_cnt++;
    end
    $display("Run covered %0d items with %0d reads and %0d results (%0d short, %0d long).",
             taken_cnt, read_cnt, result_cnt, short_cnt, long_cnt);
    $display("Thresholds were reprogrammed by %0d register writes, from 0 up to 65535 ticks.",
             write_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
